@@ hw/rtl/tilt_compensated_heading_macros.svh @@
// Assertion macros for the tilt-compensated heading block.
// Used by the top level only; expects clk and rst in scope.
`ifndef TILT_COMPENSATED_HEADING_MACROS_SVH
`define TILT_COMPENSATED_HEADING_MACROS_SVH

// checked outside reset
`define HDG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define HDG_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/hdg_pkg.sv @@
// Shared widths, constants, register codes and the arctangent table
// for the tilt-compensated heading datapath. No dependencies.
package hdg_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int COEF_BITS       = 16;
  localparam int ROW_BITS        = 3 * COEF_BITS;
  localparam int CFG_DATA_BITS   = ROW_BITS;
  localparam int ANGLE_FRAC_BITS = 6;
  localparam int HEADING_BITS    = 15;
  localparam int ANGLE_CFG_BITS  = 15;

  localparam int D_BITS  = SAMPLE_BITS + 1;
  localparam int P_BITS  = D_BITS + COEF_BITS;
  localparam int MV_BITS = P_BITS + 2;

  localparam int VEC_BITS   = 20;
  localparam int VN_BITS    = VEC_BITS + 1;
  localparam int CP_BITS    = 2 * VN_BITS;
  localparam int E_BITS     = CP_BITS + 1;
  localparam int SPLIT      = 22;
  localparam int EH_BITS    = E_BITS - SPLIT;
  localparam int SQ_BITS    = 2 * VEC_BITS + 1;
  localparam int SUM_BITS   = SQ_BITS + 2;
  localparam int ROOT_BITS  = (SUM_BITS + 1) / 2;
  localparam int ISQRT_STAGES = (ROOT_BITS + 1) / 2;
  localparam int XY_BITS    = 64;

  localparam int CORDIC_BITS   = 30;
  localparam int CORDIC_STEPS  = 31;
  localparam int CORDIC_STAGES = (CORDIC_STEPS + 1) / 2;
  localparam int CX_BITS       = CORDIC_BITS + 4;
  localparam int CZ_BITS       = CORDIC_BITS + 5;

  localparam logic [31:0] DEG_PER_RAD_Q26 = 32'd3845054675;
  localparam logic signed [CZ_BITS-1:0] PI_Q30 = 35'sd3373259426;
  localparam int FULL_TURN = 360 << ANGLE_FRAC_BITS;

  typedef enum logic [2:0] {
    REG_HARD_X   = 3'd0,
    REG_HARD_Y   = 3'd1,
    REG_HARD_Z   = 3'd2,
    REG_SOFT_R0  = 3'd3,
    REG_SOFT_R1  = 3'd4,
    REG_SOFT_R2  = 3'd5,
    REG_DECL     = 3'd6,
    REG_MOUNT    = 3'd7
  } cfg_reg_t;

  // atan(2^-i) in Q30 radians
  function automatic int atan_q30(input int i);
    int r;
    case (i)
      0:  r = 843314857;
      1:  r = 497837830;
      2:  r = 263043837;
      3:  r = 133525159;
      4:  r = 67021687;
      5:  r = 33543516;
      6:  r = 16775851;
      7:  r = 8388437;
      8:  r = 4194283;
      9:  r = 2097149;
      10: r = 1048576;
      default: r = (i > 10 && i < CORDIC_STEPS) ? (1 << (30 - i)) : 0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/hdg_mag_corr.sv @@
// Magnetometer correction: hard-iron subtract, then 3x3 soft-iron matrix.
// Three register stages. Depends on hdg_pkg.
module hdg_mag_corr import hdg_pkg::*; (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [SAMPLE_BITS-1:0] mag [3],
  input  logic signed [SAMPLE_BITS-1:0] offset [3],
  input  logic [ROW_BITS-1:0]           row [3],
  output logic signed [MV_BITS-1:0]     mv [3]
);

  logic signed [D_BITS-1:0] d [3];
  logic signed [P_BITS-1:0] p [3][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d[k] <= D_BITS'(mag[k]) - D_BITS'(offset[k]);
      end
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          p[r][k] <= $signed(row[r][COEF_BITS*k +: COEF_BITS]) * d[k];
        end
        mv[r] <= MV_BITS'(p[r][0]) + MV_BITS'(p[r][1]) + MV_BITS'(p[r][2]);
      end
    end
  end

endmodule

@@ hw/rtl/hdg_vec_norm.sv @@
// Block normalization of a vector: common power-of-two scale so the
// largest magnitude has bit length T. Two stages. Uses hdg_pkg.
module hdg_vec_norm import hdg_pkg::*; #(
  parameter int W = MV_BITS,
  parameter int T = VEC_BITS,
  parameter int N = 3
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] vin [N],
  output logic signed [T:0]   vout [N]
);

  localparam int LW = $clog2(W + 1);
  localparam int XW = (W > T + 1) ? W : T + 1;
  localparam int OW = T + 1;

  logic [W-1:0]        mag_or;
  logic [LW-1:0]       len_c;
  logic [LW-1:0]       len;
  logic signed [W-1:0] v [N];

  always_comb begin
    mag_or = '0;
    for (int i = 0; i < N; i++) begin
      mag_or = mag_or | (vin[i][W-1] ? W'(-vin[i]) : W'(vin[i]));
    end
    len_c = '0;
    for (int i = 0; i < W; i++) begin
      if (mag_or[i]) len_c = LW'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v   <= vin;
      len <= len_c;
      for (int i = 0; i < N; i++) begin
        if (int'(len) > T) begin
          vout[i] <= OW'(v[i] >>> (int'(len) - T));
        end else begin
          vout[i] <= OW'(XW'(v[i]) <<< (T - int'(len)));
        end
      end
    end
  end

endmodule

@@ hw/rtl/hdg_isqrt.sv @@
// Pipelined floor integer square root, two result bits per stage.
// Depends on hdg_pkg for widths.
module hdg_isqrt import hdg_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [SUM_BITS-1:0]  radicand,
  output logic [ROOT_BITS-1:0] root
);

  localparam int WP = SUM_BITS + 1;

  logic [WP-1:0] vr [ISQRT_STAGES];
  logic [WP-1:0] rr [ISQRT_STAGES];

  for (genvar s = 0; s < ISQRT_STAGES; s++) begin : g_st
    logic [WP-1:0] vi, ri, vc, rc, bitv;

    if (s == 0) begin : g_first
      assign vi = WP'(radicand);
      assign ri = '0;
    end else begin : g_next
      assign vi = vr[s-1];
      assign ri = rr[s-1];
    end

    always_comb begin
      vc   = vi;
      rc   = ri;
      bitv = '0;
      for (int j = 0; j < 2; j++) begin
        if (2 * s + j < ROOT_BITS) begin
          bitv = WP'(1) << (2 * (ROOT_BITS - 1 - (2 * s + j)));
          if (vc >= rc + bitv) begin
            vc = vc - (rc + bitv);
            rc = (rc >> 1) + bitv;
          end else begin
            rc = rc >> 1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vr[s] <= vc;
        rr[s] <= rc;
      end
    end
  end

  assign root = rr[ISQRT_STAGES-1][ROOT_BITS-1:0];

endmodule

@@ hw/rtl/hdg_cordic.sv @@
// Vectoring CORDIC atan2 in Q30 radians: quadrant fold, then two
// micro-rotations per stage. Depends on hdg_pkg for table and widths.
module hdg_cordic import hdg_pkg::*; (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [CORDIC_BITS:0] yin,
  input  logic signed [CORDIC_BITS:0] xin,
  output logic signed [CZ_BITS-1:0]   angle
);

  logic signed [CX_BITS-1:0] x0, y0;
  logic signed [CZ_BITS-1:0] z0;
  logic signed [CX_BITS-1:0] xr [CORDIC_STAGES];
  logic signed [CX_BITS-1:0] yr [CORDIC_STAGES];
  logic signed [CZ_BITS-1:0] zr [CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      if (xin < 0) begin
        x0 <= -CX_BITS'(xin);
        y0 <= -CX_BITS'(yin);
        z0 <= (yin >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
        x0 <= CX_BITS'(xin);
        y0 <= CX_BITS'(yin);
        z0 <= '0;
      end
    end
  end

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_st
    logic signed [CX_BITS-1:0] xi, yi, xc, yc, dx, dy;
    logic signed [CZ_BITS-1:0] zi, zc;

    if (s == 0) begin : g_first
      assign xi = x0;
      assign yi = y0;
      assign zi = z0;
    end else begin : g_next
      assign xi = xr[s-1];
      assign yi = yr[s-1];
      assign zi = zr[s-1];
    end

    always_comb begin
      xc = xi;
      yc = yi;
      zc = zi;
      dx = '0;
      dy = '0;
      for (int j = 0; j < 2; j++) begin
        if (2 * s + j < CORDIC_STEPS) begin
          dx = yc >>> (2 * s + j);
          dy = xc >>> (2 * s + j);
          if (yc > 0) begin
            xc = xc + dx;
            yc = yc - dy;
            zc = zc + CZ_BITS'(atan_q30(2 * s + j));
          end else begin
            xc = xc - dx;
            yc = yc + dy;
            zc = zc - CZ_BITS'(atan_q30(2 * s + j));
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xr[s] <= xc;
        yr[s] <= yc;
        zr[s] <= zc;
      end
    end
  end

  assign angle = zr[CORDIC_STAGES-1];

endmodule

@@ hw/rtl/tilt_compensated_heading.sv @@
// Tilt-compensated compass heading, top level: config registers, cross
// products, scaling and heading wrap. Uses hdg_pkg, the hdg_* units and
// tilt_compensated_heading_macros.svh.
//
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_stall    mag_x..z, accel_x..z
//  out       source     out_valid / out_stall  heading, valid_res
//  cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction per cycle unless the output stalls. The path holds the
// 11-stage square root and the 17-stage CORDIC. A stall with out_valid high
// freezes every stage and in_stall follows it. Reset clears valid bits and
// loads defaults (identity matrix, declination 164); cfg_ready is high.
`include "tilt_compensated_heading_macros.svh"
module tilt_compensated_heading import hdg_pkg::*; (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [SAMPLE_BITS-1:0]    mag_x,
  input  logic signed [SAMPLE_BITS-1:0]    mag_y,
  input  logic signed [SAMPLE_BITS-1:0]    mag_z,
  input  logic signed [SAMPLE_BITS-1:0]    accel_x,
  input  logic signed [SAMPLE_BITS-1:0]    accel_y,
  input  logic signed [SAMPLE_BITS-1:0]    accel_z,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [HEADING_BITS-1:0]          heading,
  output logic                             valid_res,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [2:0]                       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]         cfg_data
);

  localparam int EX_DELAY   = ISQRT_STAGES + 2 - 4;
  localparam int PIPE_DEPTH = 3 + 2 + 2 + ISQRT_STAGES + 2 + 2 + CORDIC_STAGES + 1 + 3;
  localparam int DEG_DEPTH  = 2 + CORDIC_STAGES + 1 + 2;
  localparam int UNITS_BITS = 15;
  localparam int HS_BITS    = 20;
  localparam int HP_BITS    = 17;

  logic en;

  logic signed [SAMPLE_BITS-1:0]    hard_off [3];
  logic [ROW_BITS-1:0]              soft_row [3];
  logic signed [ANGLE_CFG_BITS-1:0] declination;
  logic [ANGLE_CFG_BITS-1:0]        mount;

  logic                             vp [PIPE_DEPTH];
  logic                             deg_d [DEG_DEPTH];

  logic signed [SAMPLE_BITS-1:0] mag_in [3];
  logic signed [SAMPLE_BITS-1:0] acc_d [3][3];
  logic signed [MV_BITS-1:0]     mv [3];
  logic signed [VN_BITS-1:0]     mv_n [3];
  logic signed [VN_BITS-1:0]     av_n [3];
  logic signed [VN_BITS-1:0]     av_d [2][3];

  logic signed [CP_BITS-1:0]  cp [6];
  logic [SQ_BITS-1:0]         sq [3];
  logic signed [E_BITS-1:0]   ex, ey, ez;
  logic [SUM_BITS-1:0]        ssum;
  logic signed [CP_BITS-1:0]  pa, pb;
  logic signed [CP_BITS+1:0]  pc, pd;
  logic signed [E_BITS-1:0]   ex_t8, ex_t9;
  logic signed [XY_BITS-1:0]  nx_t9;
  logic signed [E_BITS-1:0]   ex_dly [EX_DELAY];
  logic signed [XY_BITS-1:0]  nx_dly [EX_DELAY];
  logic [ROOT_BITS-1:0]       alen;
  logic signed [CP_BITS+1:0]  ph;
  logic [CP_BITS+1:0]         pl;
  logic signed [XY_BITS-1:0]  nx_t19, nx_t20, y_t20;
  logic signed [XY_BITS-1:0]  xy_in [2];
  logic signed [CORDIC_BITS:0] xy_n [2];
  logic signed [CZ_BITS-1:0]  angle;

  logic [CZ_BITS-1:0]         absz_c;
  logic [63:0]                prod;
  logic                       zneg;
  logic [UNITS_BITS-1:0]      units_c;
  logic signed [HS_BITS-1:0]  h_c;
  logic [HP_BITS-1:0]         hpos;
  logic [HP_BITS-1:0]         wrap_c;

  assign out_valid = vp[PIPE_DEPTH-1];
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hard_off[0] <= '0;
      hard_off[1] <= '0;
      hard_off[2] <= '0;
      soft_row[0] <= 48'h0000_0000_4000;
      soft_row[1] <= 48'h0000_4000_0000;
      soft_row[2] <= 48'h4000_0000_0000;
      declination <= 15'sd164;
      mount       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_HARD_X:  hard_off[0] <= $signed(cfg_data[SAMPLE_BITS-1:0]);
        REG_HARD_Y:  hard_off[1] <= $signed(cfg_data[SAMPLE_BITS-1:0]);
        REG_HARD_Z:  hard_off[2] <= $signed(cfg_data[SAMPLE_BITS-1:0]);
        REG_SOFT_R0: soft_row[0] <= cfg_data[ROW_BITS-1:0];
        REG_SOFT_R1: soft_row[1] <= cfg_data[ROW_BITS-1:0];
        REG_SOFT_R2: soft_row[2] <= cfg_data[ROW_BITS-1:0];
        REG_DECL:    declination <= $signed(cfg_data[ANGLE_CFG_BITS-1:0]);
        REG_MOUNT:   mount       <= cfg_data[ANGLE_CFG_BITS-1:0];
        default:     ;
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_DEPTH; i++) vp[i] <= 1'b0;
    end else if (en) begin
      vp[0] <= in_valid;
      for (int i = 1; i < PIPE_DEPTH; i++) vp[i] <= vp[i-1];
    end
  end

  assign mag_in[0] = mag_x;
  assign mag_in[1] = mag_y;
  assign mag_in[2] = mag_z;

  hdg_mag_corr u_mag_corr (
    .clk    (clk),
    .en     (en),
    .mag    (mag_in),
    .offset (hard_off),
    .row    (soft_row),
    .mv     (mv)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      acc_d[0][0] <= accel_x;
      acc_d[0][1] <= accel_y;
      acc_d[0][2] <= accel_z;
      acc_d[1]    <= acc_d[0];
      acc_d[2]    <= acc_d[1];
    end
  end

  hdg_vec_norm #(.W(MV_BITS), .T(VEC_BITS), .N(3)) u_mag_norm (
    .clk  (clk),
    .en   (en),
    .vin  (mv),
    .vout (mv_n)
  );

  hdg_vec_norm #(.W(SAMPLE_BITS), .T(VEC_BITS), .N(3)) u_acc_norm (
    .clk  (clk),
    .en   (en),
    .vin  (acc_d[2]),
    .vout (av_n)
  );

  // cross products; wide second product split into partial products
  always_ff @(posedge clk) begin
    if (en) begin
      cp[0] <= mv_n[1] * av_n[2];
      cp[1] <= mv_n[2] * av_n[1];
      cp[2] <= mv_n[2] * av_n[0];
      cp[3] <= mv_n[0] * av_n[2];
      cp[4] <= mv_n[0] * av_n[1];
      cp[5] <= mv_n[1] * av_n[0];
      av_d[0] <= av_n;
      av_d[1] <= av_d[0];
      for (int k = 0; k < 3; k++) sq[k] <= SQ_BITS'(av_n[k] * av_n[k]);
      ex   <= E_BITS'(cp[0]) - E_BITS'(cp[1]);
      ey   <= E_BITS'(cp[2]) - E_BITS'(cp[3]);
      ez   <= E_BITS'(cp[4]) - E_BITS'(cp[5]);
      ssum <= SUM_BITS'(sq[0]) + SUM_BITS'(sq[1]) + SUM_BITS'(sq[2]);
      pa    <= av_d[1][1] * $signed(ez[E_BITS-1:SPLIT]);
      pb    <= av_d[1][2] * $signed(ey[E_BITS-1:SPLIT]);
      pc    <= av_d[1][1] * $signed({1'b0, ez[SPLIT-1:0]});
      pd    <= av_d[1][2] * $signed({1'b0, ey[SPLIT-1:0]});
      ex_t8 <= ex;
      nx_t9 <= ((XY_BITS'(pa) - XY_BITS'(pb)) <<< SPLIT) + (XY_BITS'(pc) - XY_BITS'(pd));
      ex_t9 <= ex_t8;
      ex_dly[0] <= ex_t9;
      nx_dly[0] <= nx_t9;
      for (int i = 1; i < EX_DELAY; i++) begin
        ex_dly[i] <= ex_dly[i-1];
        nx_dly[i] <= nx_dly[i-1];
      end
    end
  end

  hdg_isqrt u_isqrt (
    .clk      (clk),
    .en       (en),
    .radicand (ssum),
    .root     (alen)
  );

  // E.x * |a|
  always_ff @(posedge clk) begin
    if (en) begin
      ph     <= $signed(ex_dly[EX_DELAY-1][E_BITS-1:SPLIT]) * $signed({1'b0, alen});
      pl     <= ex_dly[EX_DELAY-1][SPLIT-1:0] * alen;
      nx_t19 <= nx_dly[EX_DELAY-1];
      y_t20  <= (XY_BITS'(ph) <<< SPLIT) + $signed(XY_BITS'(pl));
      nx_t20 <= nx_t19;
    end
  end

  assign xy_in[0] = y_t20;
  assign xy_in[1] = nx_t20;

  hdg_vec_norm #(.W(XY_BITS), .T(CORDIC_BITS), .N(2)) u_xy_norm (
    .clk  (clk),
    .en   (en),
    .vin  (xy_in),
    .vout (xy_n)
  );

  // degenerate flag rides alongside the angle path
  always_ff @(posedge clk) begin
    if (en) begin
      deg_d[0] <= (y_t20 == '0) && (nx_t20 == '0);
      for (int i = 1; i < DEG_DEPTH; i++) deg_d[i] <= deg_d[i-1];
    end
  end

  hdg_cordic u_cordic (
    .clk   (clk),
    .en    (en),
    .yin   (xy_n[0]),
    .xin   (xy_n[1]),
    .angle (angle)
  );

  always_comb begin
    absz_c  = angle[CZ_BITS-1] ? CZ_BITS'(-angle) : CZ_BITS'(angle);
    units_c = UNITS_BITS'((prod + (64'(1) << (55 - ANGLE_FRAC_BITS)))
                          >> (56 - ANGLE_FRAC_BITS));
    h_c     = (zneg ? -HS_BITS'(units_c) : HS_BITS'(units_c))
              + HS_BITS'(declination) - HS_BITS'(mount) + HS_BITS'(3 * FULL_TURN);
    if (hpos >= HP_BITS'(4 * FULL_TURN)) begin
      wrap_c = hpos - HP_BITS'(4 * FULL_TURN);
    end else if (hpos >= HP_BITS'(3 * FULL_TURN)) begin
      wrap_c = hpos - HP_BITS'(3 * FULL_TURN);
    end else if (hpos >= HP_BITS'(2 * FULL_TURN)) begin
      wrap_c = hpos - HP_BITS'(2 * FULL_TURN);
    end else if (hpos >= HP_BITS'(FULL_TURN)) begin
      wrap_c = hpos - HP_BITS'(FULL_TURN);
    end else begin
      wrap_c = hpos;
    end
  end

  // radians to degree units, offsets, wrap into one turn
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= absz_c[31:0] * DEG_PER_RAD_Q26;
      zneg <= angle[CZ_BITS-1];
      hpos <= HP_BITS'(h_c);
      if (deg_d[DEG_DEPTH-1]) begin
        heading   <= '0;
        valid_res <= 1'b0;
      end else begin
        heading   <= HEADING_BITS'(wrap_c);
        valid_res <= 1'b1;
      end
    end
  end

  `HDG_ASSERT(a_heading_range, out_valid |-> (heading < HEADING_BITS'(FULL_TURN)), "heading range")
  `HDG_ASSERT(a_degenerate_zero, (out_valid && !valid_res) |-> (heading == '0), "degenerate not zero")
  `HDG_ASSERT_RST(a_reset_empty, rst |=> !out_valid, "output valid after reset")

endmodule

@@ test/tilt_compensated_heading_test.sv @@
// Testbench for tilt_compensated_heading: directed and random sample pairs
// checked against an in-bench heading predictor. Depends on hdg_pkg and the RTL.
`timescale 1ns / 1ps
module tilt_compensated_heading_test;
  import hdg_pkg::*;

  typedef struct packed {
    logic [HEADING_BITS-1:0] heading;
    logic                    ok;
  } heading_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic signed [SAMPLE_BITS-1:0] mag_x = 0, mag_y = 0, mag_z = 0;
  logic signed [SAMPLE_BITS-1:0] accel_x = 0, accel_y = 0, accel_z = 0;
  logic out_stall = 0;
  logic cfg_valid = 0;
  cfg_reg_t cfg_index = REG_HARD_X;
  logic [CFG_DATA_BITS-1:0] cfg_data = 0;
  wire in_stall, out_valid, valid_res, cfg_ready;
  wire [HEADING_BITS-1:0] heading;

  tilt_compensated_heading DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .mag_x(mag_x), .mag_y(mag_y), .mag_z(mag_z),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
    .out_valid(out_valid), .out_stall(out_stall), .heading(heading),
    .valid_res(valid_res), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor copy of the registers
  logic signed [15:0] off_m [3];
  logic [47:0] soft_row [3];
  logic [14:0] decl_q, mount_q;
  longint atan_q [CORDIC_STEPS];
  longint pi_q;

  heading_t pending_headings [$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 0;
  int stall_left = 0;

  function automatic longint unsigned mag_of(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic int norm_shift(longint a, longint b, longint c, int t);
    longint unsigned mx;
    int len;
    mx = mag_of(a);
    if (mag_of(b) > mx) mx = mag_of(b);
    if (mag_of(c) > mx) mx = mag_of(c);
    len = 0;
    while (mx != 0) begin
      len++;
      mx = mx >> 1;
    end
    if (len == 0) return 0;
    return len - t;
  endfunction

  function automatic longint shift_by(longint v, int s);
    return s > 0 ? (v >>> s) : (v <<< (-s));
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic heading_t predict_heading(longint mx, longint my, longint mz,
                                               longint ax, longint ay, longint az);
    longint d [3], mv [3], av [3];
    longint ex, ey, ez, nx, y, x, z, dx, dy, h;
    longint unsigned alen, units;
    int s, r, k;
    heading_t res;
    d[0] = mx - longint'(off_m[0]);
    d[1] = my - longint'(off_m[1]);
    d[2] = mz - longint'(off_m[2]);
    for (r = 0; r < 3; r++) begin
      mv[r] = 0;
      for (k = 0; k < 3; k++)
        mv[r] += longint'($signed(soft_row[r][16*k +: 16])) * d[k];
    end
    av[0] = ax; av[1] = ay; av[2] = az;
    s = norm_shift(mv[0], mv[1], mv[2], VEC_BITS);
    for (k = 0; k < 3; k++) mv[k] = shift_by(mv[k], s);
    s = norm_shift(av[0], av[1], av[2], VEC_BITS);
    for (k = 0; k < 3; k++) av[k] = shift_by(av[k], s);
    ex = mv[1] * av[2] - mv[2] * av[1];
    ey = mv[2] * av[0] - mv[0] * av[2];
    ez = mv[0] * av[1] - mv[1] * av[0];
    nx = av[1] * ez - av[2] * ey;
    alen = floor_sqrt(longint'(av[0] * av[0]) + longint'(av[1] * av[1])
                      + longint'(av[2] * av[2]));
    y = ex * longint'(alen);
    x = nx;
    res = '0;
    if (y == 0 && x == 0) return res;
    s = norm_shift(y, x, 0, CORDIC_BITS);
    y = shift_by(y, s);
    x = shift_by(x, s);
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? pi_q : -pi_q;
      x = -x;
      y = -y;
    end
    for (k = 0; k < CORDIC_STEPS; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_q[k];
      end else begin
        x -= dx; y += dy; z -= atan_q[k];
      end
    end
    units = (mag_of(z) * 64'd3845054675 + (64'd1 << (55 - ANGLE_FRAC_BITS)))
            >> (56 - ANGLE_FRAC_BITS);
    h = (z < 0) ? -longint'(units) : longint'(units);
    h += longint'($signed(decl_q));
    h -= longint'(mount_q);
    h = h % FULL_TURN;
    if (h < 0) h += FULL_TURN;
    res.heading = h[HEADING_BITS-1:0];
    res.ok = 1;
    return res;
  endfunction

  // result checker, heading allowed +-1 LSB around the turn; also drives random output stalls
  always @(posedge clk) begin
    heading_t want;
    int diff;
    int wait_n;
    cycles <= cycles + 1;
    if (!rst) begin
      wait_n = stall_left;
      if (out_valid && !out_stall) begin
        wait_n = quiet ? 0 : $urandom_range(0, 15);
        if (pending_headings.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected transaction heading=%0d valid=%0b",
                                     heading, valid_res);
        end else begin
          want = pending_headings.pop_front();
          diff = (int'(heading) - int'(want.heading) + FULL_TURN) % FULL_TURN;
          if (valid_res !== want.ok || (want.ok && !(diff == 0 || diff == 1 ||
              diff == FULL_TURN - 1)) || (!want.ok && heading !== 0)) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected heading=%0d valid=%0b got heading=%0d valid=%0b",
                       want.heading, want.ok, heading, valid_res);
          end
        end
      end
      if (wait_n > 0) begin
        out_stall <= 1;
        stall_left <= wait_n - 1;
      end else begin
        out_stall <= 0;
        stall_left <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 2000000) begin
      $display("tilt_compensated_heading: mismatch");
      $finish;
    end
  end

  task automatic send_sample(longint mx, longint my, longint mz,
                             longint ax, longint ay, longint az);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    mag_x <= SAMPLE_BITS'(mx); mag_y <= SAMPLE_BITS'(my); mag_z <= SAMPLE_BITS'(mz);
    accel_x <= SAMPLE_BITS'(ax); accel_y <= SAMPLE_BITS'(ay); accel_z <= SAMPLE_BITS'(az);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_headings.push_back(predict_heading(longint'($signed(16'(mx))),
      longint'($signed(16'(my))), longint'($signed(16'(mz))),
      longint'($signed(16'(ax))), longint'($signed(16'(ay))),
      longint'($signed(16'(az)))));
  endtask

  task automatic drain;
    in_valid <= 0;
    @(posedge clk);
    while (pending_headings.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    case (idx)
      REG_HARD_X:  off_m[0] = val[15:0];
      REG_HARD_Y:  off_m[1] = val[15:0];
      REG_HARD_Z:  off_m[2] = val[15:0];
      REG_SOFT_R0: soft_row[0] = val;
      REG_SOFT_R1: soft_row[1] = val;
      REG_SOFT_R2: soft_row[2] = val;
      REG_DECL:    decl_q = val[14:0];
      default:     mount_q = val[14:0];
    endcase
  endtask

  function automatic logic [47:0] near_identity(int r);
    logic [47:0] v;
    int k;
    for (k = 0; k < 3; k++)
      v[16*k +: 16] = (k == r ? 16'sd16384 : 16'sd0) + $signed(16'($urandom_range(0, 4095)))
                      - 16'sd2048;
    return v;
  endfunction

  task automatic test_directed;
    send_sample(1000, 0, 0, 0, 0, 1000);
    send_sample(-1000, 0, 0, 0, 0, 1000);
    send_sample(0, 1000, 0, 0, 0, 1000);
    send_sample(0, -1000, 0, 0, 0, 1000);
    send_sample(32767, 32767, 32767, 32767, 32767, 32767);
    send_sample(-32768, -32768, -32768, -32768, -32768, -32768);
    send_sample(32767, -32768, 32767, -32768, 32767, -32768);
    send_sample(-32768, 32767, 0, 0, -32768, 32767);
    send_sample(1200, -300, 400, 0, 0, 0);
    send_sample(0, 0, 0, 100, 200, 16000);
    send_sample(100, 200, 300, 200, 400, 600);
    send_sample(500, 300, -200, 16000, 0, 0);
    send_sample(1, 0, 0, 0, 0, 1);
    send_sample(0, 1, 0, 0, 0, -1);
    send_sample(-1, -1, -1, 1, 1, 1);
    send_sample(3000, 2000, -8000, 500, -700, 16384);
    drain();
  endtask

  task automatic test_random(int n);
    int i;
    for (i = 0; i < n; i++) begin
      if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0)
        send_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        send_sample($signed(16'($urandom)) >>> $urandom_range(0, 10),
                    $signed(16'($urandom)) >>> $urandom_range(0, 10),
                    $signed(16'($urandom)) >>> $urandom_range(0, 10),
                    $signed(16'($urandom)) >>> $urandom_range(6, 12),
                    $signed(16'($urandom)) >>> $urandom_range(6, 12),
                    $signed(16'($urandom)) >>> $urandom_range(0, 2));
    end
    quiet = 0;
    drain();
  endtask

  task automatic test_calibrated;
    write_reg(REG_HARD_X, CFG_DATA_BITS'(16'($urandom_range(0, 2000) - 1000)));
    write_reg(REG_HARD_Y, CFG_DATA_BITS'(16'($urandom_range(0, 2000) - 1000)));
    write_reg(REG_HARD_Z, CFG_DATA_BITS'(16'($urandom_range(0, 2000) - 1000)));
    write_reg(REG_SOFT_R0, near_identity(0));
    write_reg(REG_SOFT_R1, near_identity(1));
    write_reg(REG_SOFT_R2, near_identity(2));
    write_reg(REG_DECL, CFG_DATA_BITS'(15'($urandom_range(0, 23040) - 11520)));
    write_reg(REG_MOUNT, CFG_DATA_BITS'($urandom_range(0, 23039)));
    test_random(200);
  endtask

  task automatic test_extremes;
    write_reg(REG_HARD_X, CFG_DATA_BITS'(16'h8000));
    write_reg(REG_HARD_Y, CFG_DATA_BITS'(16'h7FFF));
    write_reg(REG_HARD_Z, CFG_DATA_BITS'(16'h8000));
    write_reg(REG_SOFT_R0, 48'h8000_7FFF_8000);
    write_reg(REG_SOFT_R1, 48'h7FFF_8000_7FFF);
    write_reg(REG_SOFT_R2, 48'h8000_8000_7FFF);
    write_reg(REG_DECL, CFG_DATA_BITS'(15'(-11520)));
    write_reg(REG_MOUNT, CFG_DATA_BITS'(23039));
    test_random(100);
    write_reg(REG_DECL, CFG_DATA_BITS'(11520));
    write_reg(REG_MOUNT, CFG_DATA_BITS'(15'h7FFF));
    write_reg(REG_HARD_X, CFG_DATA_BITS'(16'h7FFF));
    test_random(100);
  endtask

  task automatic test_wild;
    write_reg(REG_HARD_X, CFG_DATA_BITS'($urandom));
    write_reg(REG_HARD_Y, CFG_DATA_BITS'($urandom));
    write_reg(REG_HARD_Z, CFG_DATA_BITS'($urandom));
    write_reg(REG_SOFT_R0, CFG_DATA_BITS'({$urandom, $urandom}));
    write_reg(REG_SOFT_R1, CFG_DATA_BITS'({$urandom, $urandom}));
    write_reg(REG_SOFT_R2, CFG_DATA_BITS'({$urandom, $urandom}));
    write_reg(REG_DECL, CFG_DATA_BITS'($urandom));
    write_reg(REG_MOUNT, CFG_DATA_BITS'($urandom));
    test_random(200);
  endtask

  initial begin
    int k;
    for (k = 0; k < CORDIC_STEPS; k++)
      atan_q[k] = longint'($atan(1.0 / (2.0 ** k)) * (2.0 ** 30));
    pi_q = longint'(4.0 * $atan(1.0) * (2.0 ** 30));
    off_m[0] = 0; off_m[1] = 0; off_m[2] = 0;
    soft_row[0] = 48'd16384;
    soft_row[1] = 48'd16384 << 16;
    soft_row[2] = 48'd16384 << 32;
    decl_q = 164;
    mount_q = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random(200);
    test_calibrated();
    test_extremes();
    test_wild();
    if (errors == 0)
      $display("tilt_compensated_heading: match");
    else
      $display("tilt_compensated_heading: mismatch");
    $finish;
  end
endmodule
